### src/qoi_pkg.sv
// qoi_pkg: item types, fixed-point widths and booth digit helpers for the
// quaternion orientation integrator; no dependencies
package qoi_pkg;

  localparam int unsigned RATE_W  = 24;
  localparam int unsigned STEP_W  = 24;
  localparam int unsigned QUAT_W  = 32;

  // rate times step, radix-4 booth over the zero-extended step
  localparam int unsigned RATE_STEPS = (STEP_W + 2) / 2;
  localparam int unsigned RLO_W      = 2 * RATE_STEPS;
  localparam int unsigned RP_W       = RATE_W + 2;
  localparam int unsigned URACC_W    = RATE_W + 3;
  localparam int unsigned U_W        = RATE_W + STEP_W;
  localparam int unsigned UHI_W      = U_W - RLO_W;

  // quaternion digits against the rate products, radix-4 booth
  localparam int unsigned QUAT_STEPS = QUAT_W / 2;
  localparam int unsigned QP_W       = U_W + 2;
  localparam int unsigned QACC_W     = U_W + 6;
  localparam int unsigned CNT_W      = $clog2(QUAT_STEPS);

  // full product scale is 2^-71, result scale 2^-30; halving folded in
  localparam int unsigned FRAC_DROP   = 41;
  localparam int unsigned ROUND_SHIFT = FRAC_DROP - QUAT_W;
  localparam int unsigned DELTA_W     = QACC_W - ROUND_SHIFT;
  localparam int unsigned SUM_W       = DELTA_W + 1;

  localparam logic signed [QACC_W-1:0] ROUND_HALF = QACC_W'(1) << (ROUND_SHIFT - 1);
  localparam logic signed [SUM_W-1:0]  SAT_HI     = SUM_W'(2 ** (QUAT_W - 1) - 1);
  localparam logic signed [SUM_W-1:0]  SAT_LO     = -SAT_HI - SUM_W'(1);
  localparam logic signed [QUAT_W-1:0] ORIENT_ONE = QUAT_W'(1) << (QUAT_W - 2);

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_LOAD   = 1'b1;

  // booth selector patterns {b1, b0, previous b1}
  localparam logic [2:0] BOOTH_ZERO_P = 3'b000;
  localparam logic [2:0] BOOTH_ZERO_N = 3'b111;
  localparam logic [2:0] BOOTH_TWO_P  = 3'b011;
  localparam logic [2:0] BOOTH_TWO_N  = 3'b100;

  typedef struct packed {
    logic                     operation;
    logic signed [RATE_W-1:0] rate_x;
    logic signed [RATE_W-1:0] rate_y;
    logic signed [RATE_W-1:0] rate_z;
    logic        [STEP_W-1:0] step_time;
    logic signed [QUAT_W-1:0] load_w;
    logic signed [QUAT_W-1:0] load_x;
    logic signed [QUAT_W-1:0] load_y;
    logic signed [QUAT_W-1:0] load_z;
  } in_item_t;

  typedef struct packed {
    logic signed [QUAT_W-1:0] quat_w;
    logic signed [QUAT_W-1:0] quat_x;
    logic signed [QUAT_W-1:0] quat_y;
    logic signed [QUAT_W-1:0] quat_z;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RATE,
    ST_QUAT,
    ST_FINISH
  } state_e;

  function automatic logic booth_zero(input logic [2:0] sel);
    return sel inside {BOOTH_ZERO_P, BOOTH_ZERO_N};
  endfunction

  function automatic logic booth_two(input logic [2:0] sel);
    return sel inside {BOOTH_TWO_P, BOOTH_TWO_N};
  endfunction

  function automatic logic signed [RP_W-1:0] booth_rate(
    input logic signed [RATE_W-1:0] r,
    input logic        [2:0]        sel
  );
    logic signed [RP_W-1:0] e;
    logic signed [RP_W-1:0] m;
    e = RP_W'(r);
    m = booth_two(sel) ? (e <<< 1) : e;
    if (booth_zero(sel)) begin
      return '0;
    end else if (sel[2]) begin
      return -m;
    end else begin
      return m;
    end
  endfunction

  function automatic logic signed [QP_W-1:0] booth_quat(
    input logic signed [U_W-1:0] u,
    input logic        [2:0]     sel
  );
    logic signed [QP_W-1:0] e;
    logic signed [QP_W-1:0] m;
    e = QP_W'(u);
    m = booth_two(sel) ? (e <<< 1) : e;
    if (booth_zero(sel)) begin
      return '0;
    end else if (sel[2]) begin
      return -m;
    end else begin
      return m;
    end
  endfunction

  function automatic logic signed [QUAT_W-1:0] sat_add(
    input logic signed [QUAT_W-1:0]  c,
    input logic signed [DELTA_W-1:0] d
  );
    logic signed [SUM_W-1:0] s;
    s = SUM_W'(c) + SUM_W'(d);
    if (s > SAT_HI) begin
      return QUAT_W'(SAT_HI);
    end else if (s < SAT_LO) begin
      return QUAT_W'(SAT_LO);
    end else begin
      return QUAT_W'(s);
    end
  endfunction

endpackage

### src/quaternion_orientation_integrator.sv
// update item: 13 radix-4 steps form rate times step, then 16 steps walk the
// quaternion two bits a cycle against those products, then one round/add in the
// finish step; the input is stalled until the item is done, so a new item is
// taken only once the last one is through. load item: goes straight to finish
// a finished result waits in the output register; the finish step waits until
// the output register is free. reset: identity quaternion, no result pending
module quaternion_orientation_integrator
  import qoi_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int unsigned CW = 0;
  localparam int unsigned CX = 1;
  localparam int unsigned CY = 2;
  localparam int unsigned CZ = 3;
  localparam int unsigned UX = 0;
  localparam int unsigned UY = 1;
  localparam int unsigned UZ = 2;

  state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  in_item_t item_q;
  logic [RLO_W-1:0] dt_q;
  logic dt_prev_q;

  logic signed [URACC_W-1:0] uhi_q [3];
  logic        [RLO_W-1:0]   ulo_q [3];
  logic signed [URACC_W-1:0] rsum  [3];
  logic signed [RATE_W-1:0]  rate  [3];
  logic signed [U_W-1:0]     u     [3];

  logic signed [QUAT_W-1:0] orient_q [4];
  logic                     qprev_q  [4];
  logic signed [QACC_W-1:0] acc_q    [4];
  logic signed [QACC_W-1:0] qsum     [4];
  logic signed [QP_W-1:0]   prod     [4][3];
  logic signed [QACC_W-1:0] rnd      [4];
  logic signed [DELTA_W-1:0] delta   [4];
  logic signed [QUAT_W-1:0] qnew     [4];
  logic signed [QUAT_W-1:0] load_val [4];

  out_item_t out_q;
  logic      out_valid_q;

  logic accept, rate_step, quat_step, finish, slot_free;

  assign slot_free = !out_valid_q || !out_stall_i;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    in_stall_o = 1'b1;
    accept     = 1'b0;
    rate_step  = 1'b0;
    quat_step  = 1'b0;
    finish     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cnt_d      = '0;
        if (in_valid_i) begin
          accept  = 1'b1;
          state_d = (in_item_i.operation == OP_LOAD) ? ST_FINISH : ST_RATE;
        end
      end
      ST_RATE: begin
        rate_step = 1'b1;
        cnt_d     = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(RATE_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = ST_QUAT;
        end
      end
      ST_QUAT: begin
        quat_step = 1'b1;
        cnt_d     = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(QUAT_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (slot_free) begin
          finish  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // rate times step, two bits of the step per cycle
  assign rate[UX] = item_q.rate_x;
  assign rate[UY] = item_q.rate_y;
  assign rate[UZ] = item_q.rate_z;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rsum[k] = uhi_q[k] + URACC_W'(booth_rate(rate[k], {dt_q[1:0], dt_prev_q}));
      u[k]    = {uhi_q[k][UHI_W-1:0], ulo_q[k]};
    end
  end

  // quaternion digits against the three rate products
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      for (int k = 0; k < 3; k++) begin
        prod[j][k] = booth_quat(u[k], {orient_q[j][1:0], qprev_q[j]});
      end
    end
    qsum[CW] = acc_q[CW] - QACC_W'(prod[CX][UX]) - QACC_W'(prod[CY][UY])
             - QACC_W'(prod[CZ][UZ]);
    qsum[CX] = acc_q[CX] + QACC_W'(prod[CW][UX]) + QACC_W'(prod[CZ][UY])
             - QACC_W'(prod[CY][UZ]);
    qsum[CY] = acc_q[CY] + QACC_W'(prod[CW][UY]) + QACC_W'(prod[CX][UZ])
             - QACC_W'(prod[CZ][UX]);
    qsum[CZ] = acc_q[CZ] + QACC_W'(prod[CW][UZ]) + QACC_W'(prod[CY][UX])
             - QACC_W'(prod[CX][UY]);
  end

  // low product bits never reach the rounding point, only the upper part is kept
  assign load_val[CW] = item_q.load_w;
  assign load_val[CX] = item_q.load_x;
  assign load_val[CY] = item_q.load_y;
  assign load_val[CZ] = item_q.load_z;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      rnd[j]   = acc_q[j] + ROUND_HALF;
      delta[j] = DELTA_W'(rnd[j] >>> ROUND_SHIFT);
      qnew[j]  = (item_q.operation == OP_LOAD) ? load_val[j]
                                               : sat_add(orient_q[j], delta[j]);
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q    <= in_item_i;
      dt_q      <= RLO_W'(in_item_i.step_time);
      dt_prev_q <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        uhi_q[k] <= '0;
      end
      for (int j = 0; j < 4; j++) begin
        acc_q[j]   <= '0;
        qprev_q[j] <= 1'b0;
      end
    end else if (rate_step) begin
      dt_q      <= dt_q >> 2;
      dt_prev_q <= dt_q[1];
      for (int k = 0; k < 3; k++) begin
        uhi_q[k] <= rsum[k] >>> 2;
        ulo_q[k] <= {rsum[k][1:0], ulo_q[k][RLO_W-1:2]};
      end
    end else if (quat_step) begin
      for (int j = 0; j < 4; j++) begin
        acc_q[j]   <= qsum[j] >>> 2;
        qprev_q[j] <= orient_q[j][1];
      end
    end
    if (finish) begin
      out_q.quat_w <= qnew[CW];
      out_q.quat_x <= qnew[CX];
      out_q.quat_y <= qnew[CY];
      out_q.quat_z <= qnew[CZ];
    end
  end

  // orientation rotates two bits a cycle and is back in place after the walk
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      orient_q[CW] <= ORIENT_ONE;
      orient_q[CX] <= '0;
      orient_q[CY] <= '0;
      orient_q[CZ] <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      for (int j = 0; j < 4; j++) begin
        if (finish) begin
          orient_q[j] <= qnew[j];
        end else if (quat_step) begin
          orient_q[j] <= {orient_q[j][1:0], orient_q[j][QUAT_W-1:2]};
        end
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef SYNTHESIS
  a_rate_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RATE) |-> (cnt_q < CNT_W'(RATE_STEPS)))
    else $error("rate step count out of range");

  a_out_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_FINISH))
    else $error("result appeared without a finish step");

  a_finish_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && out_valid_q && out_stall_i) |=> (state_q == ST_FINISH))
    else $error("finish overwrote a pending result");

  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |=> ($stable(orient_q[CW]) && $stable(orient_q[CX])
                              && $stable(orient_q[CY]) && $stable(orient_q[CZ])))
    else $error("orientation changed while idle");

  a_rotate_restores: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && $past(state_q) == ST_QUAT)
      |-> (orient_q[CW] == $past(orient_q[CW], QUAT_STEPS)
           && orient_q[CZ] == $past(orient_q[CZ], QUAT_STEPS)))
    else $error("orientation not restored after digit walk");
`endif

endmodule
